// File: rtl/pnf_pkg.sv
// Shared types, widths, constant tables and state codes for the 2D Perlin noise / fBm block.
// Used by pnf_mul, pnf_seq and perlin_noise_fbm_2d_top. No dependencies.
package pnf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int OCT_W   = 4;
  localparam int OUT_W   = 16;

  // Internal fixed-point formats
  localparam int INNER_W = 24;  // fraction bits of the inner noise math
  localparam int TAB_W   = 16;  // fraction bits of the frequency and gain tables
  localparam int MULT_W  = 35;  // width of a frequency table entry
  localparam int MLO_W   = 18;  // low slice of a frequency used per partial product
  localparam int GAIN_W  = 16;
  localparam int TIDX_W  = 4;   // index width of the octave tables
  localparam int FADE_W  = 25;  // fade value, up to 1.0 in Q1.24
  localparam int POLY_W  = 28;  // 10 - 15t + 6t^2 in Q.24
  localparam int G_W     = 27;  // gradient dot product
  localparam int D_W     = 28;  // difference of two gradients
  localparam int L_W     = 28;  // lerp results and single noise value
  localparam int DV_W    = 29;  // difference of the two row lerps
  localparam int ACC_W   = 48;  // octave sum in Q.40

  // Shared multiplier operand and product widths
  localparam int MA_W = 33;
  localparam int MB_W = 30;
  localparam int MP_W = MA_W + MB_W;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SX0, ST_SX1, ST_SY0, ST_SY1,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
    ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6, ST_G7,
    ST_W0, ST_W1,
    ST_DONE
  } pnf_state_t;

  // Item handed from the top level to the sequencer
  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [OCT_W-1:0]          octave_count;
  } pnf_job_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } pnf_stat_t;

  // Raw result: single noise in Q.24 or octave sum in Q.40
  typedef struct packed {
    logic                    func;
    logic signed [ACC_W-1:0] acc;
  } pnf_res_t;

  // Reference permutation of 0..255; the doubled table folds onto it with an 8-bit index
  localparam logic [7:0] PERM_TBL [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] pnf_perm(input logic [7:0] idx);
    return PERM_TBL[idx];
  endfunction

  // Octave frequency 2.3^k in Q.16, rounded
  function automatic logic [MULT_W-1:0] pnf_mult(input logic [TIDX_W-1:0] k);
    logic [MULT_W-1:0] m;
    case (k)
      4'd0:    m = 35'd65536;
      4'd1:    m = 35'd150733;
      4'd2:    m = 35'd346685;
      4'd3:    m = 35'd797377;
      4'd4:    m = 35'd1833966;
      4'd5:    m = 35'd4218122;
      4'd6:    m = 35'd9701680;
      4'd7:    m = 35'd22313864;
      4'd8:    m = 35'd51321887;
      4'd9:    m = 35'd118040341;
      4'd10:   m = 35'd271492784;
      4'd11:   m = 35'd624433403;
      4'd12:   m = 35'd1436196827;
      4'd13:   m = 35'd3303252702;
      4'd14:   m = 35'd7597481214;
      default: m = 35'd17474206791;
    endcase
    return m;
  endfunction

  // Octave weight 0.5 * 0.45^k in Q.16, rounded
  function automatic logic [GAIN_W-1:0] pnf_gain(input logic [TIDX_W-1:0] k);
    logic [GAIN_W-1:0] g;
    case (k)
      4'd0:    g = 16'd32768;
      4'd1:    g = 16'd14746;
      4'd2:    g = 16'd6636;
      4'd3:    g = 16'd2986;
      4'd4:    g = 16'd1344;
      4'd5:    g = 16'd605;
      4'd6:    g = 16'd272;
      4'd7:    g = 16'd122;
      4'd8:    g = 16'd55;
      4'd9:    g = 16'd25;
      4'd10:   g = 16'd11;
      4'd11:   g = 16'd5;
      4'd12:   g = 16'd2;
      4'd13:   g = 16'd1;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/pnf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pnf_pkg for operand and product widths.
module pnf_mul (
  input  logic                           clk,
  input  logic signed [pnf_pkg::MA_W-1:0] a,
  input  logic signed [pnf_pkg::MB_W-1:0] b,
  output logic signed [pnf_pkg::MP_W-1:0] prod
);
  import pnf_pkg::*;

  logic signed [MP_W-1:0] prod_r;

  // Multiply and register every cycle
  always_ff @(posedge clk) begin
    prod_r <= MP_W'(a * b);
  end

  assign prod = prod_r;

endmodule

// File: rtl/pnf_seq.sv
// Sequencer and datapath registers for one noise item: scaling, fade, hashing, lerps, octave sum.
// Depends on pnf_pkg; instantiates the shared multiplier pnf_mul.
module pnf_seq #(
  parameter int MAX_OCTAVES     = pnf_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = pnf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pnf_pkg::pnf_job_t   job,
  input  logic                ack,
  output pnf_pkg::pnf_stat_t  stat,
  output pnf_pkg::pnf_res_t   res
);
  import pnf_pkg::*;

  // Low bits of a scaled coordinate: 8 cell bits over the fraction
  localparam int PW = COORD_FRAC_BITS + INNER_W;
  localparam int CW = $clog2(MAX_OCTAVES + 1);

  pnf_state_t state_r, state_nxt;

  // Item and octave control
  logic                      mode_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [CW-1:0]             cnt_r, k_r;
  logic [MULT_W-1:0]         m_r;

  // Datapath registers
  logic [PW-1:0]             px_r, py_r;
  logic [INNER_W-1:0]        t2x_r, t2y_r, t3x_r, t3y_r;
  logic [POLY_W-1:0]         pxp_r, pyp_r;
  logic [FADE_W-1:0]         u_r, v_r;
  logic [7:0]                ra_r, rb_r;
  logic [1:0]                h00_r, h01_r, h10_r, h11_r;
  logic signed [G_W-1:0]     g00_r, g10_r, g01_r, g11_r;
  logic signed [D_W-1:0]     dlo_r, dhi_r;
  logic signed [L_W-1:0]     lo_r, hi_r, n_r;
  logic signed [DV_W-1:0]    dv_r;
  logic signed [ACC_W-1:0]   acc_r;

  // Multiplier and hash table
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    prod;
  logic [7:0]                rom_idx, rom_q;

  // Derived views of the registers
  logic [7:0]                xi, yi;
  logic [INNER_W-1:0]        fx, fy;
  logic signed [INNER_W:0]   xp, xm, yp, ym;
  logic signed [28:0]        q_lo;
  logic signed [29:0]        q_v;
  logic signed [L_W-1:0]     n_val;
  logic                      last_oct;

  pnf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic signed [G_W-1:0] slope(
    input logic [1:0]               h,
    input logic signed [INNER_W:0]  x,
    input logic signed [INNER_W:0]  y
  );
    logic signed [G_W-1:0] a;
    logic signed [G_W-1:0] b;
    a = h[1] ? G_W'(y) : G_W'(x);
    b = h[1] ? G_W'(x) : G_W'(y);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  // Fade polynomial 10 - 15t + 6t^2 in Q.24, always positive
  function automatic logic [POLY_W-1:0] poly(
    input logic [INNER_W-1:0] t,
    input logic [INNER_W-1:0] t2
  );
    logic [30:0] s;
    s = 31'd167772160 - 31'(t) * 31'd15 + 31'(t2) * 31'd6;
    return s[POLY_W-1:0];
  endfunction

  assign xi = px_r[PW-1 -: 8];
  assign yi = py_r[PW-1 -: 8];
  assign fx = px_r[PW-9 -: INNER_W];
  assign fy = py_r[PW-9 -: INNER_W];
  assign xp = {1'b0, fx};
  assign xm = {1'b1, fx};   // fx - 1.0
  assign yp = {1'b0, fy};
  assign ym = {1'b1, fy};

  // Floor of the lerp products back to Q.24
  assign q_lo  = $signed(prod[52:24]);
  assign q_v   = $signed(prod[53:24]);
  assign n_val = L_W'(31'(lo_r) + 31'(q_v));
  assign rom_q = pnf_perm(rom_idx);
  assign last_oct = (CW'(k_r + CW'(1)) == cnt_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, multiplier operands and hash index
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    rom_idx   = xi;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (job.func && (job.octave_count == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SX0;
          end
        end
      end
      ST_SX0: begin
        mul_a     = MA_W'(cx_r);
        mul_b     = MB_W'(m_r[MLO_W-1:0]);
        state_nxt = ST_SX1;
      end
      ST_SX1: begin
        mul_a     = MA_W'(cx_r);
        mul_b     = MB_W'(m_r[MULT_W-1:MLO_W]);
        state_nxt = ST_SY0;
      end
      ST_SY0: begin
        mul_a     = MA_W'(cy_r);
        mul_b     = MB_W'(m_r[MLO_W-1:0]);
        state_nxt = ST_SY1;
      end
      ST_SY1: begin
        mul_a     = MA_W'(cy_r);
        mul_b     = MB_W'(m_r[MULT_W-1:MLO_W]);
        state_nxt = ST_F0;
      end
      ST_F0: begin
        mul_a     = MA_W'(fx);
        mul_b     = MB_W'(fx);
        rom_idx   = xi;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        mul_a     = MA_W'(fy);
        mul_b     = MB_W'(fy);
        rom_idx   = 8'(xi + 8'd1);
        state_nxt = ST_F2;
      end
      ST_F2: begin
        mul_a     = MA_W'(t2x_r);
        mul_b     = MB_W'(fx);
        rom_idx   = 8'(ra_r + yi);
        state_nxt = ST_F3;
      end
      ST_F3: begin
        mul_a     = MA_W'(t2y_r);
        mul_b     = MB_W'(fy);
        rom_idx   = 8'(ra_r + yi + 8'd1);
        state_nxt = ST_F4;
      end
      ST_F4: begin
        mul_a     = MA_W'(t3x_r);
        mul_b     = MB_W'(pxp_r);
        rom_idx   = 8'(rb_r + yi);
        state_nxt = ST_F5;
      end
      ST_F5: begin
        mul_a     = MA_W'(t3y_r);
        mul_b     = MB_W'(pyp_r);
        rom_idx   = 8'(rb_r + yi + 8'd1);
        state_nxt = ST_G0;
      end
      ST_G0: state_nxt = ST_G1;
      ST_G1: state_nxt = ST_G2;
      ST_G2: begin
        mul_a     = MA_W'(dlo_r);
        mul_b     = MB_W'(u_r);
        state_nxt = ST_G3;
      end
      ST_G3: begin
        mul_a     = MA_W'(dhi_r);
        mul_b     = MB_W'(u_r);
        state_nxt = ST_G4;
      end
      ST_G4: state_nxt = ST_G5;
      ST_G5: state_nxt = ST_G6;
      ST_G6: begin
        mul_a     = MA_W'(dv_r);
        mul_b     = MB_W'(v_r);
        state_nxt = ST_G7;
      end
      ST_G7: begin
        state_nxt = mode_r ? ST_W0 : ST_DONE;
      end
      ST_W0: begin
        mul_a     = MA_W'(n_r);
        mul_b     = MB_W'(pnf_gain(TIDX_W'(k_r)));
        state_nxt = ST_W1;
      end
      ST_W1: begin
        state_nxt = last_oct ? ST_DONE : ST_SX0;
      end
      ST_DONE: begin
        if (ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers, loaded by state
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_r <= job.func;
          cx_r   <= job.coord_x;
          cy_r   <= job.coord_y;
          k_r    <= '0;
          acc_r  <= '0;
          m_r    <= pnf_mult('0);
          if (!job.func) begin
            cnt_r <= CW'(1);
          end else if (5'(job.octave_count) > 5'(MAX_OCTAVES)) begin
            cnt_r <= CW'(MAX_OCTAVES);
          end else begin
            cnt_r <= CW'(job.octave_count);
          end
        end
      end
      // Assemble the scaled coordinates from two partial products each
      ST_SX1: px_r <= prod[PW-1:0];
      ST_SY0: px_r <= PW'(px_r + {prod[PW-MLO_W-1:0], {MLO_W{1'b0}}});
      ST_SY1: py_r <= prod[PW-1:0];
      ST_F0: begin
        py_r <= PW'(py_r + {prod[PW-MLO_W-1:0], {MLO_W{1'b0}}});
        ra_r <= rom_q;
      end
      // Fade chains for x and y, interleaved; hash lookups run alongside
      ST_F1: begin
        t2x_r <= prod[47:24];
        rb_r  <= rom_q;
      end
      ST_F2: begin
        t2y_r <= prod[47:24];
        h00_r <= rom_q[1:0];
      end
      ST_F3: begin
        t3x_r <= prod[47:24];
        pxp_r <= poly(fx, t2x_r);
        h01_r <= rom_q[1:0];
      end
      ST_F4: begin
        t3y_r <= prod[47:24];
        pyp_r <= poly(fy, t2y_r);
        h10_r <= rom_q[1:0];
      end
      ST_F5: begin
        u_r   <= prod[48:24];
        h11_r <= rom_q[1:0];
      end
      // Gradients and lerps
      ST_G0: begin
        v_r   <= prod[48:24];
        g00_r <= slope(h00_r, xp, yp);
        g10_r <= slope(h10_r, xm, yp);
      end
      ST_G1: begin
        g01_r <= slope(h01_r, xp, ym);
        g11_r <= slope(h11_r, xm, ym);
        dlo_r <= D_W'(g10_r) - D_W'(g00_r);
      end
      ST_G2: dhi_r <= D_W'(g11_r) - D_W'(g01_r);
      ST_G3: lo_r  <= L_W'(30'(g00_r) + 30'(q_lo));
      ST_G4: hi_r  <= L_W'(30'(g01_r) + 30'(q_lo));
      ST_G5: dv_r  <= DV_W'(hi_r) - DV_W'(lo_r);
      ST_G7: begin
        n_r <= n_val;
        if (!mode_r) acc_r <= ACC_W'(n_val);
      end
      // Weight the octave, add it in and advance
      ST_W1: begin
        acc_r <= acc_r + prod[ACC_W-1:0];
        if (!last_oct) begin
          k_r <= CW'(k_r + CW'(1));
          m_r <= pnf_mult(TIDX_W'(k_r + CW'(1)));
        end
      end
      default: ;
    endcase
  end

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE);
  assign res.func  = mode_r;
  assign res.acc   = acc_r;

endmodule

// File: rtl/perlin_noise_fbm_2d_top.sv
// 2D improved Perlin noise and fBm octave sum: a new item is taken only when the sequencer is idle.
// Mode 0 gives a single noise value, mode 1 a weighted sum of N octaves. Every
// product of an octave (scaling, fade, lerps, weight) goes through one shared 33x30
// multiplier in turn. The result register lets the next item start while a result waits.
// Depends on pnf_pkg; instantiates pnf_seq.
module perlin_noise_fbm_2d_top #(
  parameter int MAX_OCTAVES     = pnf_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = pnf_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = pnf_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic signed [pnf_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pnf_pkg::COORD_W-1:0] in_coord_y,
  input  logic [pnf_pkg::OCT_W-1:0]          in_octave_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pnf_pkg::OUT_W-1:0]   out_noise_out
);
  import pnf_pkg::*;

  // Rounding shifts from the Q.24 single value and the Q.40 octave sum
  localparam int D0 = INNER_W - OUT_FRAC_BITS;
  localparam int D1 = INNER_W + TAB_W - OUT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  pnf_job_t  job;
  pnf_stat_t stat;
  pnf_res_t  res;
  logic      start, ack;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_noise_r;
  logic signed [ACC_W-1:0] sum0, sum1, rsel;
  logic signed [OUT_W-1:0] sat;

  assign job.func         = in_func;
  assign job.coord_x      = in_coord_x;
  assign job.coord_y      = in_coord_y;
  assign job.octave_count = in_octave_count;

  assign in_stall = stat.busy;
  assign start    = in_valid && !in_stall;

  // Hand the result over once the output register is free
  assign ack = stat.done && (!out_valid_r || !out_stall);

  pnf_seq #(
    .MAX_OCTAVES     (MAX_OCTAVES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .job   (job),
    .ack   (ack),
    .stat  (stat),
    .res   (res)
  );

  // Round half up to the output format, then saturate
  always_comb begin
    sum0 = res.acc + (ACC_W'(1) << (D0 - 1));
    sum1 = res.acc + (ACC_W'(1) << (D1 - 1));
    rsel = res.func ? (sum1 >>> D1) : (sum0 >>> D0);
    if (rsel > SAT_HI) begin
      sat = OUT_W'(SAT_HI);
    end else if (rsel < SAT_LO) begin
      sat = OUT_W'(SAT_LO);
    end else begin
      sat = OUT_W'(rsel);
    end
  end

  // Output register: load on hand-over, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_noise_r <= sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_noise_out = out_noise_r;

endmodule
